// File: sv/salsa20_stream_cipher_core_assert.svh
// assertion macros shared by salsa_core and salsa_back
// clocked on aclk, switched off while aresetn is low
`ifndef SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SALSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SALSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SALSA_ASSERT_IMP(lbl, ante, cons)
`define SALSA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: sv/salsa_pkg.sv
package salsa_pkg;

    localparam int WordW   = 32;
    localparam int NumRegs = 5;
    localparam int CfgW    = 64;
    localparam int CtrW    = 64;
    localparam int NumWords = 16;
    // 10 double rounds, 4 half steps each
    localparam int LastStep = 40;
    localparam int StepW    = 6;

    typedef logic [WordW-1:0] word_t;
    typedef logic [3:0]       pos_t;
    typedef logic [CtrW-1:0]  ctr_t;
    typedef logic [2:0]       reg_idx_t;
    typedef logic [StepW-1:0] step_t;

    typedef logic [NumRegs-1:0][CfgW-1:0] cfg_t;
    typedef word_t [NumWords-1:0]         block_t;

    // register indexes of the configuration port
    localparam reg_idx_t REG_KEY01 = 3'd0;
    localparam reg_idx_t REG_KEY23 = 3'd1;
    localparam reg_idx_t REG_KEY45 = 3'd2;
    localparam reg_idx_t REG_KEY67 = 3'd3;
    localparam reg_idx_t REG_NONCE = 3'd4;

    // expansion constants, as supplied before the byte swap
    localparam word_t SIGMA0 = 32'h6578_7061;
    localparam word_t SIGMA1 = 32'h6E64_2033;
    localparam word_t SIGMA2 = 32'h322D_6279;
    localparam word_t SIGMA3 = 32'h7465_206B;

    // quarter round word indexes a, b, c, d: column round then row round
    localparam pos_t QR_IDX [2][4][4] = '{
        '{ '{4'd0,  4'd4,  4'd8,  4'd12},
           '{4'd5,  4'd9,  4'd13, 4'd1 },
           '{4'd10, 4'd14, 4'd2,  4'd6 },
           '{4'd15, 4'd3,  4'd7,  4'd11} },
        '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
           '{4'd5,  4'd6,  4'd7,  4'd4 },
           '{4'd10, 4'd11, 4'd8,  4'd9 },
           '{4'd15, 4'd12, 4'd13, 4'd14} }
    };

    // queued item: message word and what the back end must do with it
    typedef struct packed {
        word_t msg;
        logic  new_block;
        logic  restart;
    } item_t;

    // back end to round core
    typedef struct packed {
        logic start;
        logic abort;
        logic take;
        ctr_t ctr;
    } core_ctl_t;

    // round core to back end
    typedef struct packed {
        logic busy;
        logic valid;
        ctr_t ctr;
    } core_stat_t;

    function automatic word_t bswap32(word_t w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic word_t rotl(word_t v, int unsigned r);
        return (v << r) | (v >> (WordW - r));
    endfunction

    // starting state of one block
    function automatic block_t init_state(cfg_t cfg, ctr_t ctr);
        block_t s;
        s[0]  = bswap32(SIGMA0);
        s[5]  = bswap32(SIGMA1);
        s[10] = bswap32(SIGMA2);
        s[15] = bswap32(SIGMA3);
        s[1]  = bswap32(cfg[REG_KEY01][31:0]);
        s[2]  = bswap32(cfg[REG_KEY01][63:32]);
        s[3]  = bswap32(cfg[REG_KEY23][31:0]);
        s[4]  = bswap32(cfg[REG_KEY23][63:32]);
        s[11] = bswap32(cfg[REG_KEY45][31:0]);
        s[12] = bswap32(cfg[REG_KEY45][63:32]);
        s[13] = bswap32(cfg[REG_KEY67][31:0]);
        s[14] = bswap32(cfg[REG_KEY67][63:32]);
        s[6]  = bswap32(cfg[REG_NONCE][31:0]);
        s[7]  = bswap32(cfg[REG_NONCE][63:32]);
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        return s;
    endfunction

endpackage

// File: sv/salsa_front.sv
module salsa_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // message_word
    input  logic [0:0]         s_tuser,   // first_word
    output salsa_pkg::item_t   head,
    output logic               head_valid,
    input  logic               head_pop
);
    import salsa_pkg::*;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    item_t             q_mem [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg;
    logic [QPtrW-1:0]  rd_ptr_reg;
    logic [QPtrW:0]    count_reg;
    pos_t              pos_reg;
    pos_t              pos_next;
    logic              push;
    item_t             in_item;

    assign s_tready   = (count_reg != (QPtrW+1)'(QDepth));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    // classify the beat: first word or block boundary needs a fresh block
    always_comb begin
        in_item.msg       = s_tdata;
        in_item.restart   = s_tuser[0];
        in_item.new_block = s_tuser[0] || (pos_reg == '0);
        pos_next          = s_tuser[0] ? pos_t'(1) : pos_reg + pos_t'(1);
    end

    // queue pointers and word position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                pos_reg    <= pos_next;
            end
            if (head_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPtrW+1)'(push) - (QPtrW+1)'(head_pop);
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: sv/salsa_core.sv
module salsa_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  salsa_pkg::core_ctl_t  ctl,
    input  salsa_pkg::cfg_t       cfg,
    output salsa_pkg::core_stat_t stat,
    output salsa_pkg::block_t     ks
);
    import salsa_pkg::*;
    `include "salsa20_stream_cipher_core_assert.svh"

    block_t x_reg;
    block_t x_next;
    block_t init_reg;
    block_t ks_reg;
    block_t ffw;
    ctr_t   ctr_reg;
    step_t  step_reg;
    logic   busy_reg;
    logic   valid_reg;

    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;
    assign stat.ctr   = ctr_reg;
    assign ks         = ks_reg;

    // half a quarter round on all four quarters in parallel
    always_comb begin
        pos_t  ia;
        pos_t  ib;
        pos_t  ic;
        pos_t  id;
        word_t t1;
        word_t t2;
        logic  row;
        x_next = x_reg;
        row    = step_reg[1];
        for (int q = 0; q < 4; q++) begin
            ia = QR_IDX[row][q][0];
            ib = QR_IDX[row][q][1];
            ic = QR_IDX[row][q][2];
            id = QR_IDX[row][q][3];
            if (!step_reg[0]) begin
                t1 = x_reg[ib] ^ rotl(x_reg[ia] + x_reg[id], 7);
                t2 = x_reg[ic] ^ rotl(t1 + x_reg[ia], 9);
                x_next[ib] = t1;
                x_next[ic] = t2;
            end else begin
                t1 = x_reg[id] ^ rotl(x_reg[ic] + x_reg[ib], 13);
                t2 = x_reg[ia] ^ rotl(t1 + x_reg[ic], 18);
                x_next[id] = t1;
                x_next[ia] = t2;
            end
        end
    end

    // feed-forward and output byte swap
    always_comb begin
        for (int i = 0; i < NumWords; i++) begin
            ffw[i] = bswap32(x_reg[i] + init_reg[i]);
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (ctl.abort) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else if (ctl.start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (busy_reg) begin
            if (step_reg == step_t'(LastStep)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end else begin
                step_reg <= step_reg + step_t'(1);
            end
        end else if (ctl.take) begin
            valid_reg <= 1'b0;
        end
    end

    // working state and finished block
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            ctr_reg  <= ctl.ctr;
            init_reg <= init_state(cfg, ctl.ctr);
            x_reg    <= init_state(cfg, ctl.ctr);
        end else if (busy_reg) begin
            if (step_reg == step_t'(LastStep)) begin
                ks_reg <= ffw;
            end else begin
                x_reg <= x_next;
            end
        end
    end

    `SALSA_ASSERT_NXT(a_block_done, busy_reg && step_reg == step_t'(LastStep) && !ctl.abort, valid_reg && !busy_reg)
    `SALSA_ASSERT_IMP(a_busy_valid_excl, busy_reg || valid_reg, busy_reg != valid_reg)

endmodule

// File: sv/salsa_back.sv
module salsa_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  salsa_pkg::item_t      head,
    input  logic                  head_valid,
    output logic                  head_pop,
    input  salsa_pkg::core_stat_t core_stat,
    input  salsa_pkg::block_t     core_ks,
    output salsa_pkg::core_ctl_t  core_ctl,
    input  logic                  cfg_wr,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata    // out_word
);
    import salsa_pkg::*;
    `include "salsa20_stream_cipher_core_assert.svh"

    block_t ks_reg;
    pos_t   pos_reg;
    ctr_t   ctr_reg;
    logic   out_valid_reg;
    word_t  out_data_reg;
    ctr_t   need_ctr;
    logic   res_match;
    logic   stale;
    logic   out_free;
    logic   fire;
    word_t  ks_word;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // which block the head beat needs and whether the core holds it
    always_comb begin
        need_ctr  = head.restart ? '0 : ctr_reg;
        res_match = core_stat.valid && (core_stat.ctr == need_ctr);
        stale     = head_valid && head.new_block && core_stat.valid && !res_match;
        out_free  = !out_valid_reg || m_tready;
        fire      = head_valid && out_free && (!head.new_block || res_match);
        ks_word   = head.new_block ? core_ks[0] : ks_reg[pos_reg];
        head_pop  = fire;
    end

    // round core control: prefetch the next block whenever the core is free and no configuration write is in progress
    always_comb begin
        core_ctl.abort = cfg_wr;
        core_ctl.take  = (fire && head.new_block) || stale;
        core_ctl.start = !core_stat.busy && !core_stat.valid && !cfg_wr;
        core_ctl.ctr   = (head_valid && head.new_block && head.restart) ? '0 : ctr_reg;
    end

    // position, block counter and output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                out_valid_reg <= 1'b1;
                if (head.new_block) begin
                    pos_reg <= pos_t'(1);
                    ctr_reg <= need_ctr + ctr_t'(1);
                end else begin
                    pos_reg <= pos_reg + pos_t'(1);
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // keystream block and output word
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= head.msg ^ ks_word;
            if (head.new_block) begin
                ks_reg <= core_ks;
            end
        end
    end

    `SALSA_ASSERT_NXT(a_pos_after_block, fire && head.new_block, pos_reg == pos_t'(1))
    `SALSA_ASSERT_NXT(a_ctr_advance, fire && head.new_block, ctr_reg == $past(need_ctr) + ctr_t'(1))

endmodule

// File: sv/salsa20_stream_cipher_core.sv
// a queued beat is XORed into the output register once its keystream block is ready; it waits
//   while the block is built, and first for any prefetch for another counter to finish
// throughput: one word per cycle inside a block while the output is not stalled; blocks come
//   from the round unit (half of four quarter rounds per cycle, 40 steps + feed-forward), which
//   starts a new block only after the previous one has been taken
// reset: synchronous, active low; clears queue, counters, key and nonce; afterwards the core starts on block 0
module salsa20_stream_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // message_word
    input  logic [0:0]  s_tuser,    // first_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import salsa_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    item_t      head;
    logic       head_valid;
    logic       head_pop;
    core_ctl_t  core_ctl;
    core_stat_t core_stat;
    block_t     core_ks;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // key and nonce registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67, REG_NONCE: begin
                    cfg_reg[cfg_index] <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    salsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    salsa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (core_ctl),
        .cfg     (cfg_reg),
        .stat    (core_stat),
        .ks      (core_ks)
    );

    salsa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .core_stat  (core_stat),
        .core_ks    (core_ks),
        .core_ctl   (core_ctl),
        .cfg_wr     (cfg_wr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
